[hdl/risc_subset_instruction_step_assert.svh]
// Assertion macros for the RTL of the instruction step block.
`ifndef RISC_SUBSET_INSTRUCTION_STEP_ASSERT_SVH
`define RISC_SUBSET_INSTRUCTION_STEP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RSIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rsis: invariant violated");

// A condition that must be followed by a consequence in the next cycle.
`define RSIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsis: sequence violated");

`endif

[hdl/rsis_pkg.sv]
// Shared constants, types and helpers of the instruction step block.
package rsis_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(MEM_ROWS);
    localparam int RF_DEPTH  = 16;
    localparam logic [31:0] FIT_LIMIT = 32'(MEM_BYTES - 4);
    localparam logic [3:0]  REG_PC    = 4'd15;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_REG_RD = 2'd2,
        KIND_MEM_RD = 2'd3
    } kind_t;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // One access to the byte memory; a word at any byte address.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [31:0] wdata;
    } mem_req_t;

    // What the execute stage decides for the current instruction.
    typedef struct packed {
        logic        bad;
        logic        rf_we;
        logic [3:0]  rf_widx;
        logic [31:0] rf_wdata;
        logic        flags_we;
        logic [3:0]  flags_new;
        logic        ld;
        logic        st;
        logic        post;
        logic        oor;
        logic [31:0] acc_addr;
        logic [31:0] post_addr;
    } exec_res_t;

    function automatic logic fits(input logic [31:0] a);
        return a <= FIT_LIMIT;
    endfunction

endpackage

[hdl/rsis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/rsis_regfile.sv]
// Register file r0..r14 in a RAM, with per-entry valid bits for reset.
module rsis_regfile import rsis_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        re,
    input  logic [3:0]  ridx,
    output logic [31:0] q,
    input  logic        we,
    input  logic [3:0]  widx,
    input  logic [31:0] wdata
);

    logic [RF_DEPTH-1:0] valid_reg;
    logic [RF_DEPTH-1:0] valid_next;
    logic                vq_reg;
    logic [31:0]         ram_q;

    rsis_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (widx),
        .wdata (wdata),
        .re    (re),
        .raddr (ridx),
        .rdata (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[widx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            vq_reg <= valid_reg[ridx];
        end
    end

    // An entry never written reads as its reset value of zero.
    assign q = vq_reg ? ram_q : 32'd0;

endmodule

[hdl/rsis_bytemem.sv]
// Byte-addressed memory in four byte lanes, with a clearing pass after reset.
module rsis_bytemem import rsis_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [31:0] rdata,
    output logic        busy
);

    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [ROW_W-1:0] clr_row_reg;
    logic [ROW_W-1:0] clr_row_next;
    logic [1:0]       off_reg;
    logic [ROW_W-1:0] lane_row [4];
    logic [7:0]       lane_wd [4];
    logic [7:0]       lane_q [4];
    logic [1:0]       lane_k [4];
    logic [16:0]      lane_sum [4];
    logic             lane_we;
    logic             lane_re;

    always_comb
    begin
        lane_we = clr_busy_reg || (req.en && req.we);
        lane_re = !clr_busy_reg && req.en && !req.we;
        for (int j = 0; j < 4; j++)
        begin
            // Lane j holds the byte of the word at offset k.
            lane_k[j]   = 2'(j) - req.addr[1:0];
            lane_sum[j] = {1'b0, req.addr} + {15'd0, lane_k[j]};
            if (clr_busy_reg)
            begin
                lane_row[j] = clr_row_reg;
                lane_wd[j]  = 8'd0;
            end
            else
            begin
                lane_row[j] = lane_sum[j][ROW_W+1:2];
                lane_wd[j]  = req.wdata[8*lane_k[j] +: 8];
            end
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        rsis_ram #(.WIDTH(8), .DEPTH(MEM_ROWS)) u_lane (
            .clk   (clk),
            .we    (lane_we),
            .waddr (lane_row[j]),
            .wdata (lane_wd[j]),
            .re    (lane_re),
            .raddr (lane_row[j]),
            .rdata (lane_q[j])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rdata[8*k +: 8] = lane_q[2'(off_reg + 2'(k))];
        end
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_row_next  = clr_row_reg;
        if (clr_busy_reg)
        begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(MEM_ROWS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_re)
        begin
            off_reg <= req.addr[1:0];
        end
    end

    assign busy = clr_busy_reg;

endmodule

[hdl/rsis_exec.sv]
// Operand shifter and multiplier stage, then the execute decision logic.
module rsis_exec import rsis_pkg::*; (
    input  logic        clk,
    input  logic        ops_en,
    input  logic [31:0] ir,
    input  logic [31:0] rm_val,
    input  logic [31:0] rs_val,
    input  logic [31:0] rn_val,
    input  logic [31:0] rd_val,
    input  logic [31:0] cur_pc,
    input  logic [3:0]  flags,
    output exec_res_t   res
);

    logic [31:0] opb_reg;
    logic        opcy_reg;
    logic [31:0] prod_reg;

    logic        cy_in;
    logic [32:0] regop;
    logic [32:0] immop;
    logic [32:0] opnd;
    logic [4:0]  rot;
    logic [63:0] imm_dbl;
    logic [4:0]  amt5;

    logic [3:0]  op;
    logic        is_mul;
    logic        cond_ok;
    logic [31:0] mul_res;
    logic [31:0] alu_res;
    logic        alu_cy;
    logic [32:0] add_sum;
    logic [31:0] xaddr;
    logic [31:0] acc;
    logic [31:0] target;

    // Returns {carry, result}; amt is at least one.
    function automatic logic [32:0] barrel(input logic [1:0] typ, input logic [7:0] amt,
                                           input logic [31:0] v);
        logic [32:0] t;
        logic [63:0] d;
        logic [4:0]  a;
        a = amt[4:0];
        t = '0;
        d = '0;
        case (typ)
            SH_LSL:
            begin
                if (amt < 8'd32)
                begin
                    t = {1'b0, v} << a;
                end
                else
                begin
                    t = {(amt == 8'd32) ? v[0] : 1'b0, 32'd0};
                end
            end
            SH_LSR:
            begin
                if (amt < 8'd32)
                begin
                    d[32:0] = {v, 1'b0} >> a;
                    t = {d[0], d[32:1]};
                end
                else
                begin
                    t = {(amt == 8'd32) ? v[31] : 1'b0, 32'd0};
                end
            end
            SH_ASR:
            begin
                if (amt < 8'd32)
                begin
                    d[32:0] = 33'($signed({v, 1'b0}) >>> a);
                    t = {d[0], d[32:1]};
                end
                else
                begin
                    t = {v[31], {32{v[31]}}};
                end
            end
            default:
            begin
                if (a == 5'd0)
                begin
                    t = {v[31], v};
                end
                else
                begin
                    d = {v, v} >> a;
                    t = {d[31], d[31:0]};
                end
            end
        endcase
        return t;
    endfunction

    // Shifter operand and carry.
    always_comb
    begin
        cy_in = ir[26] ? 1'b0 : flags[1];
        amt5  = ir[11:7];
        if (ir[4])
        begin
            if (ir[7] || rs_val[7:0] == 8'd0)
            begin
                regop = {cy_in, rm_val};
            end
            else
            begin
                regop = barrel(ir[6:5], rs_val[7:0], rm_val);
            end
        end
        else if (amt5 == 5'd0)
        begin
            case (ir[6:5])
                SH_LSL:  regop = {cy_in, rm_val};
                SH_ROR:  regop = {rm_val[0], cy_in, rm_val[31:1]};
                default: regop = barrel(ir[6:5], 8'd32, rm_val);
            endcase
        end
        else
        begin
            regop = barrel(ir[6:5], {3'd0, amt5}, rm_val);
        end

        rot     = {ir[11:8], 1'b0};
        imm_dbl = {24'd0, ir[7:0], 24'd0, ir[7:0]} >> rot;
        if (rot == 5'd0)
        begin
            immop = {cy_in, 24'd0, ir[7:0]};
        end
        else
        begin
            immop = {imm_dbl[31], imm_dbl[31:0]};
        end

        if (ir[26])
        begin
            opnd = ir[25] ? regop : {cy_in, 20'd0, ir[11:0]};
        end
        else
        begin
            opnd = ir[25] ? immop : regop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops_en)
        begin
            opb_reg  <= opnd[31:0];
            opcy_reg <= opnd[32];
            prod_reg <= rm_val * rs_val;
        end
    end

    always_comb
    begin
        case (ir[31:28])
            COND_EQ: cond_ok = flags[2];
            COND_NE: cond_ok = !flags[2];
            COND_GE: cond_ok = flags[3] == flags[0];
            COND_LT: cond_ok = flags[3] != flags[0];
            COND_GT: cond_ok = !flags[2] && (flags[3] == flags[0]);
            COND_LE: cond_ok = flags[2] || (flags[3] != flags[0]);
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        op      = ir[24:21];
        is_mul  = (ir[27:26] == 2'b00) && (ir[25:22] == 4'd0) && (ir[7:4] == 4'b1001);
        mul_res = prod_reg + (ir[21] ? rd_val : 32'd0);
        add_sum = {1'b0, rn_val} + {1'b0, opb_reg};
        alu_cy  = opcy_reg;
        case (op)
            OP_AND, OP_TST: alu_res = rn_val & opb_reg;
            OP_EOR, OP_TEQ: alu_res = rn_val ^ opb_reg;
            OP_SUB, OP_CMP:
            begin
                alu_res = rn_val - opb_reg;
                alu_cy  = rn_val >= opb_reg;
            end
            OP_RSB:
            begin
                alu_res = opb_reg - rn_val;
                alu_cy  = opb_reg >= rn_val;
            end
            OP_ADD:
            begin
                alu_res = add_sum[31:0];
                alu_cy  = add_sum[32];
            end
            OP_ORR:  alu_res = rn_val | opb_reg;
            default: alu_res = opb_reg;
        endcase
        xaddr  = ir[23] ? rn_val + opb_reg : rn_val - opb_reg;
        acc    = ir[24] ? xaddr : rn_val;
        target = cur_pc + {{6{ir[23]}}, ir[23:0], 2'b00} + 32'd8;

        res = '0;
        case (ir[27:26])
            2'b00:
            begin
                if (is_mul)
                begin
                    if (cond_ok)
                    begin
                        res.rf_we     = 1'b1;
                        res.rf_widx   = ir[19:16];
                        res.rf_wdata  = mul_res;
                        res.flags_we  = ir[20];
                        res.flags_new = {mul_res[31], mul_res == 32'd0, flags[1], flags[0]};
                    end
                end
                else if (op inside {OP_ADC, OP_SBC, OP_RSC, OP_CMN, OP_BIC, OP_MVN})
                begin
                    res.bad = 1'b1;
                end
                else if (cond_ok)
                begin
                    res.rf_we     = !(op inside {OP_TST, OP_TEQ, OP_CMP});
                    res.rf_widx   = ir[15:12];
                    res.rf_wdata  = alu_res;
                    res.flags_we  = ir[20];
                    res.flags_new = {alu_res[31], alu_res == 32'd0, alu_cy, flags[0]};
                end
            end
            2'b01:
            begin
                if (ir[22:21] != 2'b00)
                begin
                    res.bad = 1'b1;
                end
                else if (cond_ok)
                begin
                    res.ld        = fits(acc) && ir[20];
                    res.st        = fits(acc) && !ir[20];
                    res.oor       = !fits(acc);
                    res.post      = !ir[24];
                    res.acc_addr  = acc;
                    res.post_addr = xaddr;
                end
            end
            2'b10:
            begin
                if (ir[25:24] != 2'b10)
                begin
                    res.bad = 1'b1;
                end
                else if (cond_ok && target < 32'(MEM_BYTES))
                begin
                    res.rf_we    = 1'b1;
                    res.rf_widx  = REG_PC;
                    res.rf_wdata = target;
                end
            end
            default: res.bad = 1'b1;
        endcase
    end

endmodule

[hdl/risc_subset_instruction_step.sv]
// Top level of the instruction step block: item sequencer, PC, flags and output stage.
//
// The block holds fifteen general registers in a small RAM, the program
// counter and the N/Z/C/V flags in flip-flops, and a byte memory of
// MEM_BYTES bytes built from four byte-lane RAMs, so that a little-endian
// word at any byte address is read or written in one access. After reset
// the memory is cleared one row of four bytes per cycle; no item is
// accepted during that pass. An item is taken into an input register
// whenever that register is empty, so the next item waits inside the block
// while the current one is worked on, and a finished result sits in the
// output register until the receiver takes it. A step goes through fetch,
// four register reads through the single read port of the register RAM,
// the shifter and multiplier stage and execute; a load then writes the
// loaded word and a post-indexed transfer the base, each through the single
// write port. A step that fetches a zero word halts after the fetch, and
// one whose fetch address lies outside memory skips the fetch. That register
// RAM port is what sets the step rate.
`include "risc_subset_instruction_step_assert.svh"

module risc_subset_instruction_step import rsis_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [31:0] write_data,
    input  logic [3:0]  register_index,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] read_data,
    output logic        halted,
    output logic        bad_instruction,
    output logic        out_of_range,
    output logic [15:0] program_counter
);

    typedef enum logic [13:0] {
        ST_CLEAR = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_REGRD = 14'b00000000000100,
        ST_MEMRD = 14'b00000000001000,
        ST_FETCH = 14'b00000000010000,
        ST_RM    = 14'b00000000100000,
        ST_RS    = 14'b00000001000000,
        ST_RN    = 14'b00000010000000,
        ST_RD    = 14'b00000100000000,
        ST_OPS   = 14'b00001000000000,
        ST_EXEC  = 14'b00010000000000,
        ST_LOAD  = 14'b00100000000000,
        ST_POST  = 14'b01000000000000,
        ST_FIN   = 14'b10000000000000
    } state_t;

    // Control state.
    state_t      state_reg,      state_next;
    logic        buf_valid_reg,  buf_valid_next;
    logic        out_valid_reg,  out_valid_next;
    logic [31:0] pc_reg,         pc_next;
    logic [3:0]  flags_reg,      flags_next;

    // Item payload and work registers.
    logic [1:0]  buf_kind_reg;
    logic [15:0] buf_addr_reg;
    logic [31:0] buf_wdata_reg;
    logic [3:0]  buf_idx_reg;
    logic [31:0] cur_pc_reg,     cur_pc_next;
    logic [31:0] ir_reg,         ir_next;
    logic [31:0] rm_reg,         rm_next;
    logic [31:0] rs_reg,         rs_next;
    logic [31:0] rn_reg,         rn_next;
    logic [31:0] rd_reg,         rd_next;
    logic        pc_written_reg, pc_written_next;
    logic        advance_reg,    advance_next;
    logic        step_reg,       step_next;
    logic        ld_post_reg,    ld_post_next;
    logic [31:0] post_addr_reg,  post_addr_next;
    logic [31:0] res_data_reg,   res_data_next;
    logic        res_halt_reg,   res_halt_next;
    logic        res_bad_reg,    res_bad_next;
    logic        res_oor_reg,    res_oor_next;
    logic [31:0] rdata_out_reg,  rdata_out_next;
    logic        halt_out_reg,   halt_out_next;
    logic        bad_out_reg,    bad_out_next;
    logic        oor_out_reg,    oor_out_next;
    logic [15:0] pc_out_reg,     pc_out_next;

    logic        accept;
    logic        consume;
    logic        fire;
    logic [31:0] pc_fin;
    logic        wb_en;
    logic [3:0]  wb_idx;
    logic [31:0] wb_data;
    logic        rf_re;
    logic [3:0]  rf_ridx;
    logic [31:0] rf_q;
    logic        rf_we;
    mem_req_t    mem_req;
    logic [31:0] mem_rdata;
    logic        mem_busy;
    logic        ops_en;
    exec_res_t   ex;

    // Operand read: r15 gives the instruction address plus eight.
    function automatic logic [31:0] opnd(input logic [3:0] idx, input logic [31:0] q,
                                         input logic [31:0] pc);
        return (idx == REG_PC) ? pc + 32'd8 : q;
    endfunction

    rsis_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (rf_re),
        .ridx  (rf_ridx),
        .q     (rf_q),
        .we    (rf_we),
        .widx  (wb_idx),
        .wdata (wb_data)
    );

    rsis_bytemem u_bytemem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    rsis_exec u_exec (
        .clk    (clk),
        .ops_en (ops_en),
        .ir     (ir_reg),
        .rm_val (rm_reg),
        .rs_val (rs_reg),
        .rn_val (rn_reg),
        .rd_val (rd_reg),
        .cur_pc (cur_pc_reg),
        .flags  (flags_reg),
        .res    (ex)
    );

    assign req_stall = buf_valid_reg || mem_busy;
    assign accept    = req_valid && !req_stall;
    assign fire      = !out_valid_reg || !rsp_stall;
    assign pc_fin    = (step_reg && advance_reg && !pc_written_reg) ? cur_pc_reg + 32'd4
                                                                     : pc_reg;

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        flags_next      = flags_reg;
        cur_pc_next     = cur_pc_reg;
        ir_next         = ir_reg;
        rm_next         = rm_reg;
        rs_next         = rs_reg;
        rn_next         = rn_reg;
        rd_next         = rd_reg;
        pc_written_next = pc_written_reg;
        advance_next    = advance_reg;
        step_next       = step_reg;
        ld_post_next    = ld_post_reg;
        post_addr_next  = post_addr_reg;
        res_data_next   = res_data_reg;
        res_halt_next   = res_halt_reg;
        res_bad_next    = res_bad_reg;
        res_oor_next    = res_oor_reg;
        rdata_out_next  = rdata_out_reg;
        halt_out_next   = halt_out_reg;
        bad_out_next    = bad_out_reg;
        oor_out_next    = oor_out_reg;
        pc_out_next     = pc_out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        consume         = 1'b0;
        ops_en          = 1'b0;
        rf_re           = 1'b0;
        rf_ridx         = buf_idx_reg;
        wb_en           = 1'b0;
        wb_idx          = ir_reg[15:12];
        wb_data         = mem_rdata;
        mem_req         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                if (!mem_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    consume         = 1'b1;
                    res_data_next   = 32'd0;
                    res_halt_next   = 1'b0;
                    res_bad_next    = 1'b0;
                    res_oor_next    = 1'b0;
                    step_next       = 1'b0;
                    advance_next    = 1'b0;
                    pc_written_next = 1'b0;
                    state_next      = ST_FIN;
                    case (kind_t'(buf_kind_reg))
                        KIND_LOAD:
                        begin
                            if (fits({16'd0, buf_addr_reg}))
                            begin
                                mem_req = '{en: 1'b1, we: 1'b1, addr: buf_addr_reg,
                                            wdata: buf_wdata_reg};
                            end
                            else
                            begin
                                res_oor_next = 1'b1;
                            end
                        end
                        KIND_REG_RD:
                        begin
                            if (buf_idx_reg == REG_PC)
                            begin
                                res_data_next = pc_reg;
                            end
                            else
                            begin
                                rf_re      = 1'b1;
                                state_next = ST_REGRD;
                            end
                        end
                        KIND_MEM_RD:
                        begin
                            if (fits({16'd0, buf_addr_reg}))
                            begin
                                mem_req    = '{en: 1'b1, we: 1'b0, addr: buf_addr_reg,
                                               wdata: 32'd0};
                                state_next = ST_MEMRD;
                            end
                            else
                            begin
                                res_oor_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            step_next   = 1'b1;
                            cur_pc_next = pc_reg;
                            if (!fits(pc_reg))
                            begin
                                res_halt_next = 1'b1;
                                res_oor_next  = 1'b1;
                            end
                            else
                            begin
                                mem_req    = '{en: 1'b1, we: 1'b0, addr: pc_reg[15:0],
                                               wdata: 32'd0};
                                state_next = ST_FETCH;
                            end
                        end
                    endcase
                end
            end
            ST_REGRD:
            begin
                res_data_next = rf_q;
                state_next    = ST_FIN;
            end
            ST_MEMRD:
            begin
                res_data_next = mem_rdata;
                state_next    = ST_FIN;
            end
            ST_FETCH:
            begin
                ir_next = mem_rdata;
                if (mem_rdata == 32'd0)
                begin
                    // A zero word halts and leaves the PC on it.
                    res_halt_next = 1'b1;
                    state_next    = ST_FIN;
                end
                else
                begin
                    advance_next = 1'b1;
                    rf_re        = 1'b1;
                    rf_ridx      = mem_rdata[3:0];
                    state_next   = ST_RM;
                end
            end
            ST_RM:
            begin
                rm_next    = opnd(ir_reg[3:0], rf_q, cur_pc_reg);
                rf_re      = 1'b1;
                rf_ridx    = ir_reg[11:8];
                state_next = ST_RS;
            end
            ST_RS:
            begin
                rs_next    = opnd(ir_reg[11:8], rf_q, cur_pc_reg);
                rf_re      = 1'b1;
                rf_ridx    = ir_reg[19:16];
                state_next = ST_RN;
            end
            ST_RN:
            begin
                rn_next    = opnd(ir_reg[19:16], rf_q, cur_pc_reg);
                rf_re      = 1'b1;
                rf_ridx    = ir_reg[15:12];
                state_next = ST_RD;
            end
            ST_RD:
            begin
                rd_next    = opnd(ir_reg[15:12], rf_q, cur_pc_reg);
                state_next = ST_OPS;
            end
            ST_OPS:
            begin
                ops_en     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                res_bad_next   = ex.bad;
                res_oor_next   = ex.oor;
                wb_en          = ex.rf_we;
                wb_idx         = ex.rf_widx;
                wb_data        = ex.rf_wdata;
                ld_post_next   = ex.post;
                post_addr_next = ex.post_addr;
                if (ex.flags_we)
                begin
                    flags_next = ex.flags_new;
                end
                if (ex.st || ex.ld)
                begin
                    mem_req = '{en: 1'b1, we: ex.st, addr: ex.acc_addr[15:0], wdata: rd_reg};
                end
                if (ex.ld)
                begin
                    state_next = ST_LOAD;
                end
                else if (ex.post)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_LOAD:
            begin
                wb_en      = 1'b1;
                wb_idx     = ir_reg[15:12];
                wb_data    = mem_rdata;
                state_next = ld_post_reg ? ST_POST : ST_FIN;
            end
            ST_POST:
            begin
                // Base write-back comes after the loaded word, so it wins.
                wb_en      = 1'b1;
                wb_idx     = ir_reg[19:16];
                wb_data    = post_addr_reg;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fire)
                begin
                    pc_next        = pc_fin;
                    rdata_out_next = step_reg ? {flags_reg, 28'd0} : res_data_reg;
                    halt_out_next  = res_halt_reg;
                    bad_out_next   = res_bad_reg;
                    oor_out_next   = res_oor_reg;
                    pc_out_next    = pc_fin[15:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The PC lives in its own register; all other writes go to the RAM.
        rf_we = wb_en && (wb_idx != REG_PC);
        if (wb_en && wb_idx == REG_PC)
        begin
            pc_next         = wb_data;
            pc_written_next = 1'b1;
        end
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (accept)
        begin
            buf_valid_next = 1'b1;
        end
        else if (consume)
        begin
            buf_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            buf_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= 32'd0;
            flags_reg      <= 4'd0;
            pc_written_reg <= 1'b0;
            advance_reg    <= 1'b0;
            step_reg       <= 1'b0;
            ld_post_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            buf_valid_reg  <= buf_valid_next;
            out_valid_reg  <= out_valid_next;
            pc_reg         <= pc_next;
            flags_reg      <= flags_next;
            pc_written_reg <= pc_written_next;
            advance_reg    <= advance_next;
            step_reg       <= step_next;
            ld_post_reg    <= ld_post_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_kind_reg  <= kind;
            buf_addr_reg  <= address;
            buf_wdata_reg <= write_data;
            buf_idx_reg   <= register_index;
        end
        cur_pc_reg    <= cur_pc_next;
        ir_reg        <= ir_next;
        rm_reg        <= rm_next;
        rs_reg        <= rs_next;
        rn_reg        <= rn_next;
        rd_reg        <= rd_next;
        post_addr_reg <= post_addr_next;
        res_data_reg  <= res_data_next;
        res_halt_reg  <= res_halt_next;
        res_bad_reg   <= res_bad_next;
        res_oor_reg   <= res_oor_next;
        rdata_out_reg <= rdata_out_next;
        halt_out_reg  <= halt_out_next;
        bad_out_reg   <= bad_out_next;
        oor_out_reg   <= oor_out_next;
        pc_out_reg    <= pc_out_next;
    end

    assign rsp_valid       = out_valid_reg;
    assign read_data       = rdata_out_reg;
    assign halted          = halt_out_reg;
    assign bad_instruction = bad_out_reg;
    assign out_of_range    = oor_out_reg;
    assign program_counter = pc_out_reg;

    `RSIS_ASSERT(a_no_accept_in_clear, mem_busy |-> (req_stall && (state_reg == ST_CLEAR)))
    `RSIS_ASSERT(a_rf_never_pc, rf_we |-> (wb_idx != REG_PC))
    `RSIS_ASSERT(a_store_fits, (mem_req.en && mem_req.we) |-> fits({16'd0, mem_req.addr}))
    `RSIS_ASSERT_NEXT(a_fin_delivers, (state_reg == ST_FIN) && fire, rsp_valid && (state_reg == ST_IDLE))

endmodule

[tb/sv/risc_subset_instruction_step_tb.sv]
// Self-checking testbench for the instruction step block: directed programs, random items.
module risc_subset_instruction_step_tb;
    import rsis_pkg::*;

    // One expected or observed result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        halted;
        logic        bad_instruction;
        logic        out_of_range;
        logic [15:0] program_counter;
    } step_result_t;

    // Scoreboard: holds its own copy of the machine state, predicts each accepted
    // item and compares the block's results in order.
    class step_scoreboard;
        logic [31:0] regs[16];
        logic [3:0]  nzcv;
        logic [7:0]  mem[int];
        logic [31:0] cur_pc;
        bit          pc_wr;
        step_result_t pending[$];
        int          errors;
        int          mismatches;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            nzcv = '0;
            mem.delete();
            pending.delete();
            errors = 0;
            mismatches = 0;
        endfunction

        function bit in_mem(logic [31:0] a);
            return a <= 32'(MEM_BYTES - 4);
        endfunction

        function logic [31:0] rd_word(logic [31:0] a);
            logic [31:0] v;
            v = '0;
            for (int i = 0; i < 4; i++)
                if (mem.exists(int'(a) + i)) v[8*i +: 8] = mem[int'(a) + i];
            return v;
        endfunction

        function void wr_word(logic [31:0] a, logic [31:0] v);
            for (int i = 0; i < 4; i++) mem[int'(a) + i] = v[8*i +: 8];
        endfunction

        function logic [31:0] rreg(logic [3:0] r);
            return (r == REG_PC) ? cur_pc + 32'd8 : regs[r];
        endfunction

        function void wreg(logic [3:0] r, logic [31:0] v);
            regs[r] = v;
            if (r == REG_PC) pc_wr = 1;
        endfunction

        function bit cond_ok(logic [3:0] c);
            logic n, z, v;
            n = nzcv[3];
            z = nzcv[2];
            v = nzcv[0];
            case (c)
                COND_EQ: return z;
                COND_NE: return !z;
                COND_GE: return n == v;
                COND_LT: return n != v;
                COND_GT: return !z && n == v;
                COND_LE: return z || n != v;
                COND_AL: return 1;
                default: return 0;
            endcase
        endfunction

        // Shifts by an amount of at least one, carry out through cy.
        function logic [31:0] shift_val(logic [1:0] st, int amt, logic [31:0] v,
                                        inout logic cy);
            int a;
            case (st)
                SH_LSL: begin
                    if (amt < 32) begin cy = v[32-amt]; return v << amt; end
                    cy = (amt == 32) ? v[0] : 1'b0;
                    return '0;
                end
                SH_LSR: begin
                    if (amt < 32) begin cy = v[amt-1]; return v >> amt; end
                    cy = (amt == 32) ? v[31] : 1'b0;
                    return '0;
                end
                SH_ASR: begin
                    if (amt < 32) begin cy = v[amt-1]; return $signed(v) >>> amt; end
                    cy = v[31];
                    return {32{v[31]}};
                end
                default: begin
                    a = amt % 32;
                    if (a == 0) begin cy = v[31]; return v; end
                    cy = v[a-1];
                    return (v >> a) | (v << (32 - a));
                end
            endcase
        endfunction

        function logic [31:0] shifted_reg(logic [31:0] w, inout logic cy);
            logic [31:0] v;
            logic [1:0]  st;
            int amt;
            logic [31:0] r;
            v = rreg(w[3:0]);
            st = w[6:5];
            if (w[4]) begin
                if (w[7]) return v;
                amt = rreg(w[11:8]) & 32'hFF;
                return (amt == 0) ? v : shift_val(st, amt, v, cy);
            end
            amt = int'(w[11:7]);
            if (amt == 0) begin
                if (st == SH_LSL) return v;
                if (st == SH_ROR) begin
                    r = {cy, v[31:1]};
                    cy = v[0];
                    return r;
                end
                amt = 32;
            end
            return shift_val(st, amt, v, cy);
        endfunction

        function void set_nzc(logic [31:0] res, logic c);
            nzcv = {res[31], res == 0, c, nzcv[0]};
        endfunction

        function bit data_proc(logic [31:0] w);
            logic [3:0]  op;
            logic [31:0] a, b, res;
            logic        cy;
            int rot;
            op = w[24:21];
            if (op inside {OP_ADC, OP_SBC, OP_RSC, OP_CMN, OP_BIC, OP_MVN}) return 0;
            if (!cond_ok(w[31:28])) return 1;
            cy = nzcv[1];
            if (w[25]) begin
                b = {24'd0, w[7:0]};
                rot = w[11:8] * 2;
                if (rot != 0) begin
                    b = (b >> rot) | (b << (32 - rot));
                    cy = b[31];
                end
            end else begin
                b = shifted_reg(w, cy);
            end
            a = rreg(w[19:16]);
            case (op)
                OP_AND, OP_TST: res = a & b;
                OP_EOR, OP_TEQ: res = a ^ b;
                OP_SUB, OP_CMP: begin res = a - b; cy = a >= b; end
                OP_RSB: begin res = b - a; cy = b >= a; end
                OP_ADD: begin res = a + b; cy = res < a; end
                OP_ORR: res = a | b;
                default: res = b;
            endcase
            if (!(op inside {OP_TST, OP_TEQ, OP_CMP})) wreg(w[15:12], res);
            if (w[20]) set_nzc(res, cy);
            return 1;
        endfunction

        function void multiply(logic [31:0] w);
            logic [31:0] res;
            if (!cond_ok(w[31:28])) return;
            res = rreg(w[3:0]) * rreg(w[11:8]);
            if (w[21]) res += rreg(w[15:12]);
            wreg(w[19:16], res);
            if (w[20]) set_nzc(res, nzcv[1]);
        endfunction

        function bit transfer(logic [31:0] w);
            logic [31:0] off, base, addr, acc;
            logic        cy;
            bit          oor;
            cy = 0;
            oor = 0;
            if (!cond_ok(w[31:28])) return 0;
            off = w[25] ? shifted_reg(w, cy) : {20'd0, w[11:0]};
            base = rreg(w[19:16]);
            addr = w[23] ? base + off : base - off;
            acc = w[24] ? addr : base;
            if (in_mem(acc)) begin
                if (w[20]) wreg(w[15:12], rd_word(acc));
                else wr_word(acc, rreg(w[15:12]));
            end else begin
                oor = 1;
            end
            if (!w[24]) wreg(w[19:16], addr);
            return oor;
        endfunction

        function void branch(logic [31:0] w);
            logic [31:0] tgt;
            if (!cond_ok(w[31:28])) return;
            tgt = cur_pc + ({{8{w[23]}}, w[23:0]} << 2) + 32'd8;
            if (tgt < MEM_BYTES) wreg(REG_PC, tgt);
        endfunction

        // Predicts the result of one accepted item.
        function void note_item(kind_t k, logic [15:0] addr, logic [31:0] wd,
                                logic [3:0] ri);
            step_result_t e;
            logic [31:0] w;
            logic [31:0] a32;
            e = '0;
            a32 = {16'd0, addr};
            case (k)
                KIND_LOAD: if (in_mem(a32)) wr_word(a32, wd); else e.out_of_range = 1;
                KIND_REG_RD: e.read_data = regs[ri];
                KIND_MEM_RD: if (in_mem(a32)) e.read_data = rd_word(a32);
                             else e.out_of_range = 1;
                default: begin
                    cur_pc = regs[REG_PC];
                    if (!in_mem(cur_pc)) begin
                        e.halted = 1;
                        e.out_of_range = 1;
                    end else begin
                        w = rd_word(cur_pc);
                        if (w == 0) begin
                            e.halted = 1;
                        end else begin
                            pc_wr = 0;
                            case (w[27:26])
                                2'd0: if (w[25:22] == 0 && w[7:4] == 4'b1001) multiply(w);
                                      else if (!data_proc(w)) e.bad_instruction = 1;
                                2'd1: if (w[22:21] == 0) e.out_of_range = transfer(w);
                                      else e.bad_instruction = 1;
                                2'd2: if (w[25:24] == 2'd2) branch(w);
                                      else e.bad_instruction = 1;
                                default: e.bad_instruction = 1;
                            endcase
                            if (!pc_wr) regs[REG_PC] = cur_pc + 32'd4;
                        end
                    end
                    e.read_data = {nzcv, 28'd0};
                end
            endcase
            e.program_counter = regs[REG_PC][15:0];
            pending.push_back(e);
        endfunction

        // Compares one result with the oldest prediction.
        function void check_result(step_result_t got);
            step_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result item %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (mismatches++ < 10)
                    $display("mismatch: read_data %h/%h halted %b/%b bad %b/%b oor %b/%b pc %h/%h",
                             e.read_data, got.read_data, e.halted, got.halted,
                             e.bad_instruction, got.bad_instruction,
                             e.out_of_range, got.out_of_range,
                             e.program_counter, got.program_counter);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [31:0] write_data;
    logic [3:0]  register_index;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [31:0] read_data;
    logic        halted;
    logic        bad_instruction;
    logic        out_of_range;
    logic [15:0] program_counter;

    step_scoreboard board;
    bit   sending_done;
    bit   hold_off;
    logic [15:0] prog_ptr;

    risc_subset_instruction_step dut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one, and runs with none at all.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one item and holds it until the block takes it. The scoreboard notes
    // the item at the edge of acceptance, so predictions follow acceptance order.
    task automatic send_item(kind_t k, logic [15:0] a, logic [31:0] d, logic [3:0] r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid      <= 1'b1;
        kind           <= k;
        address        <= a;
        write_data     <= d;
        register_index <= r;
        do
            @(posedge clk);
        while (req_stall);
        board.note_item(k, a, d, r);
    endtask

    task automatic load_word(logic [15:0] a, logic [31:0] d);
        send_item(KIND_LOAD, a, d, 4'($urandom));
    endtask

    task automatic step_once();
        send_item(KIND_STEP, 16'($urandom), $urandom, 4'($urandom));
    endtask

    // Places one instruction at the program pointer and executes it.
    task automatic run_instr(logic [31:0] w);
        load_word(prog_ptr, w);
        step_once();
        prog_ptr = board.regs[REG_PC][15:0];
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Keeps random words from sending the program counter out of memory.
    function automatic logic [31:0] keep_pc(logic [31:0] w);
        logic [31:0] k;
        k = w;
        if (k[27:26] != 2'b10)
        begin
            if (k[15:12] == REG_PC) k[15:12] = 4'd1;
            if (k[19:16] == REG_PC) k[19:16] = 4'd2;
        end
        return k;
    endfunction

    // Random data processing word; mostly executable, sometimes odd opcodes.
    function automatic logic [31:0] rand_dp();
        logic [31:0] w;
        w = $urandom;
        w[27:26] = 2'b00;
        if ($urandom_range(0, 3) != 0) w[31:28] = COND_AL;
        if ($urandom_range(0, 7) != 0 && w[24:21] inside {OP_ADC, OP_SBC, OP_RSC,
                                                          OP_CMN, OP_BIC, OP_MVN})
            w[24:21] = OP_ADD;
        return keep_pc(w);
    endfunction

    // Random transfer word, mostly with r13 as its base register.
    function automatic logic [31:0] rand_xfer();
        logic [31:0] w;
        w = $urandom;
        w[27:26] = 2'b01;
        if ($urandom_range(0, 7) != 0) w[22:21] = 2'b00;
        if ($urandom_range(0, 3) != 0) w[31:28] = COND_AL;
        if ($urandom_range(0, 5) != 0) w[19:16] = 4'd13;
        return keep_pc(w);
    endfunction

    function automatic logic [31:0] rand_mul();
        logic [31:0] w;
        w = $urandom;
        w[27:22] = '0;
        w[7:4] = 4'b1001;
        if ($urandom_range(0, 3) != 0) w[31:28] = COND_AL;
        if (w[19:16] == REG_PC) w[19:16] = 4'd3;
        return w;
    endfunction

    function automatic logic [31:0] rand_branch();
        logic [31:0] w;
        w = $urandom;
        w[27:24] = 4'b1010;
        if ($urandom_range(0, 3) != 0) w[23:0] = 24'($signed($urandom_range(0, 16)) - 4);
        return w;
    endfunction

    // Stimulus process.
    initial
    begin
        int choice;
        logic [31:0] w;
        board = new();
        board.clear();
        sending_done   = 0;
        hold_off       = 0;
        prog_ptr       = '0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        kind           = KIND_LOAD;
        address        = '0;
        write_data     = '0;
        register_index = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes of the item fields and each special case.
        load_word(16'h0000, 32'hFFFF_FFFF);
        send_item(KIND_MEM_RD, 16'h0000, '0, 4'hF);
        load_word(16'hFFFC, 32'hA5A5_5A5A);
        send_item(KIND_MEM_RD, 16'hFFFC, '0, '0);
        load_word(16'hFFFD, 32'h1234_5678);
        send_item(KIND_MEM_RD, 16'hFFFF, '0, '0);
        load_word(16'h0000, 32'h0000_0000);
        step_once();
        prog_ptr = 16'h0000;
        run_instr(32'hE3A0_00FF);    // move immediate, unrotated
        run_instr(32'hE3B0_14FF);    // move rotated immediate with flags
        run_instr(32'hE090_2001);    // add registers
        run_instr(32'hE251_3001);    // subtract setting flags
        run_instr(32'hE1B0_4FC1);    // arithmetic shift right of a negative value
        run_instr(32'hE1B0_5061);    // rotate with extend
        run_instr(32'hE002_0391);    // multiply
        run_instr(32'hE038_4192);    // multiply accumulate with flags
        run_instr(32'hE58F_1010);    // store relative to the program counter
        run_instr(32'hE49D_2004);    // post-indexed load with write-back
        run_instr(32'hE6E0_0000);    // unsupported transfer encoding
        run_instr(32'hE0A0_0000);    // unsupported opcode
        run_instr(32'h0A00_0001);    // conditional branch
        run_instr(32'hEAFF_FFFF);    // branch to the following word
        for (int r = 0; r < 16; r++) send_item(KIND_REG_RD, '0, '0, 4'(r));
        wait_drained();
        run_instr(32'hE3A0_F000);    // back to address zero
        prog_ptr = board.regs[REG_PC][15:0];

        // Random part: mostly small programs of valid instructions, some noise.
        for (int n = 0; n < 200; n++)
        begin
            if (n == 100) hold_off = 1;
            choice = $urandom_range(0, 99);
            if (board.regs[REG_PC] > 32'h3000 || prog_ptr > 16'h3000)
            begin
                run_instr(32'hE3A0_F000);
                prog_ptr = 16'h0000;
            end else if (choice < 30) run_instr(rand_dp());
            else if (choice < 45) run_instr(rand_xfer());
            else if (choice < 55) run_instr(rand_mul());
            else if (choice < 63) run_instr(rand_branch());
            else if (choice < 68) begin
                w = keep_pc($urandom);
                run_instr(w);
            end else if (choice < 75) begin
                // Base register near the top of memory for out-of-range transfers.
                run_instr({COND_AL, 8'h3A, 4'h0, 4'd13, 12'hCFF});
            end else if (choice < 80) step_once();
            else if (choice < 88)
                send_item(KIND_REG_RD, 16'($urandom), $urandom, 4'($urandom));
            else if (choice < 94)
                send_item(KIND_MEM_RD, 16'($urandom), $urandom, 4'($urandom));
            else load_word(16'($urandom), $urandom);
            prog_ptr = board.regs[REG_PC][15:0];
        end

        // The program counter leaves memory for good, so this comes last.
        run_instr(32'hE3A0_F801);    // write the program counter
        step_once();                 // fetch beyond memory
        send_item(KIND_REG_RD, '0, '0, REG_PC);
        req_valid <= 1'b0;
        sending_done = 1;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps offering.
    initial
    begin
        int g;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 0;
                rsp_stall <= 1'b1;
                repeat (200) @(posedge clk);
            end
            g = gap_len();
            if (g > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (g - 1) @(posedge clk);
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result({read_data, halted, bad_instruction, out_of_range,
                                program_counter});

    // End of run.
    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("risc_subset_instruction_step test passed");
        else
            $display("risc_subset_instruction_step test failed");
        $finish;
    end

    // Covers the memory clearing pass, about 400 items and long gaps.
    initial
    begin
        #2000000;
        $display("risc_subset_instruction_step test failed");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/rsis_pkg.sv
hdl/rsis_ram.sv
hdl/rsis_regfile.sv
hdl/rsis_bytemem.sv
hdl/rsis_exec.sv
hdl/risc_subset_instruction_step.sv
tb/sv/risc_subset_instruction_step_tb.sv
